/* rtl/ohgs_pkg.sv */
// Shared constants, codes and types of the one-hot gather-sum block.
package ohgs_pkg;

  localparam int NUM_FIELDS = 4;
  localparam int TABLE_ROWS = 256;
  localparam int EMBED_DIM  = 8;

  // Query items carry four category fields on the port
  localparam int IN_FIELDS = 4;
  localparam int FIELD_LIM = (NUM_FIELDS < IN_FIELDS) ? NUM_FIELDS : IN_FIELDS;

  localparam int RANGE_W   = 9;
  localparam int USED_W    = 3;
  localparam int CAT_W     = 8;
  localparam int TROW_W    = 8;
  localparam int TCOL_W    = 3;
  localparam int VAL_W     = 16;
  localparam int COL_OUT_W = 3;
  localparam int SUM_W     = 18;
  localparam int CFG_IDX_W = 3;

  localparam int ROW_W  = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int LANE_W = (EMBED_DIM > 1) ? $clog2(EMBED_DIM) : 1;
  localparam int FLD_W  = (FIELD_LIM > 1) ? $clog2(FIELD_LIM) : 1;
  localparam int BASE_W = RANGE_W + FLD_W + 1;
  localparam int CMP_W  = ((BASE_W > ROW_W + 1) ? BASE_W : ROW_W + 1) + 1;
  localparam int ACC_W  = VAL_W + FLD_W + 2;

  // Stream payload layout
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 24;
  localparam int TROW_LSB    = 0;
  localparam int TCOL_LSB    = TROW_LSB + TROW_W;
  localparam int TVAL_LSB    = TCOL_LSB + TCOL_W;
  localparam int CAT_LSB     = TVAL_LSB + VAL_W;

  localparam logic [RANGE_W-1:0] RANGE_RST = RANGE_W'(64);
  localparam logic [USED_W-1:0]  USED_RST  = USED_W'(4);

  localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'(131071);
  localparam logic signed [ACC_W-1:0] SUM_MIN = -ACC_W'(131072);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE0 = 3'd0,
    CFG_RANGE1 = 3'd1,
    CFG_RANGE2 = 3'd2,
    CFG_RANGE3 = 3'd3,
    CFG_USED   = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_GATHER,
    BK_FINAL,
    BK_EMIT
  } back_state_t;

  // One classified request, as queued between front and back
  typedef struct packed {
    op_t                                op;
    logic                               bad;
    logic [FLD_W-1:0]                   last_fld;
    logic [FIELD_LIM-1:0][ROW_W-1:0]    rows;
    logic [ROW_W-1:0]                   wr_row;
    logic [LANE_W-1:0]                  wr_lane;
    logic [VAL_W-1:0]                   wr_value;
  } job_t;

endpackage

/* rtl/ohgs_front.sv */
// Front end: configuration registers, request intake and row/range classification.
module ohgs_front
  import ohgs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [RANGE_W-1:0]    cfg_data,
  input  logic                  q_full,
  output logic                  q_push,
  output job_t                  q_job
);

  logic [RANGE_W-1:0] range_r [IN_FIELDS];
  logic [USED_W-1:0]  used_r;

  logic [TROW_W-1:0]  t_row;
  logic [TCOL_W-1:0]  t_col;
  logic               wr_ok;
  logic [FLD_W-1:0]   last_fld;
  logic [BASE_W-1:0]  base;
  logic [BASE_W-1:0]  row_full;
  logic [CAT_W-1:0]   cat;
  logic               bad;
  logic [FIELD_LIM-1:0][ROW_W-1:0] rows;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < IN_FIELDS; i++) range_r[i] <= RANGE_RST;
      used_r <= USED_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RANGE0: range_r[0] <= cfg_data;
        CFG_RANGE1: range_r[1] <= cfg_data;
        CFG_RANGE2: range_r[2] <= cfg_data;
        CFG_RANGE3: range_r[3] <= cfg_data;
        CFG_USED:   used_r     <= cfg_data[USED_W-1:0];
        default: ;
      endcase
    end
  end

  assign t_row = in_tdata[TROW_LSB +: TROW_W];
  assign t_col = in_tdata[TCOL_LSB +: TCOL_W];
  assign wr_ok = (CMP_W'(t_row) < CMP_W'(TABLE_ROWS)) && (CMP_W'(t_col) < CMP_W'(EMBED_DIM));

  // Zero fields counts as one; counts above the field limit saturate
  always_comb begin
    if (used_r == '0) begin
      last_fld = '0;
    end else if (used_r > USED_W'(FIELD_LIM)) begin
      last_fld = FLD_W'(FIELD_LIM - 1);
    end else begin
      last_fld = FLD_W'(used_r - USED_W'(1));
    end
  end

  // Row of field f is the running sum of earlier ranges plus its category
  always_comb begin
    base     = '0;
    bad      = 1'b0;
    row_full = '0;
    cat      = '0;
    rows     = '0;
    for (int f = 0; f < FIELD_LIM; f++) begin
      cat      = in_tdata[CAT_LSB + f*CAT_W +: CAT_W];
      row_full = base + BASE_W'(cat);
      if (FLD_W'(f) <= last_fld) begin
        if (CMP_W'(cat) >= CMP_W'(range_r[f])) bad = 1'b1;
        if (CMP_W'(row_full) >= CMP_W'(TABLE_ROWS)) bad = 1'b1;
      end
      rows[f] = row_full[ROW_W-1:0];
      base    = base + BASE_W'(range_r[f]);
    end
  end

  always_comb begin
    q_job.op       = op_t'(in_tuser);
    q_job.bad      = bad;
    q_job.last_fld = last_fld;
    q_job.rows     = rows;
    q_job.wr_row   = ROW_W'(t_row);
    q_job.wr_lane  = LANE_W'(t_col);
    q_job.wr_value = in_tdata[TVAL_LSB +: VAL_W];
  end

  // Out-of-table writes are taken and dropped here
  assign q_push = in_tvalid && in_tready && ((op_t'(in_tuser) == OP_QUERY) || wr_ok);

endmodule

/* rtl/ohgs_fifo.sv */
// Short request queue between the front end and the back end.
module ohgs_fifo
  import ohgs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic empty
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + (QPTR_W+1)'(1);
    if (pop && !push) count_nxt = count_r - (QPTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

endmodule

/* rtl/ohgs_back.sv */
// Back end: per-column table lanes, field gather/accumulate and result output.
module ohgs_back
  import ohgs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  job_t                   q_job,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  back_state_t       state_r, state_nxt;
  job_t              cur_r;
  logic [FLD_W-1:0]  fld_r, fld_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              load_cur, acc_clr, emit, mem_we;
  logic [ROW_W-1:0]  rd_addr;

  logic                 out_valid_r, out_valid_nxt;
  logic [COL_OUT_W-1:0] out_col_r;
  logic [SUM_W-1:0]     out_sum_r;
  logic                 out_bad_r, out_last_r;

  logic signed [ACC_W-1:0] acc_sel;
  logic [SUM_W-1:0]        sum_sat;

  wire [EMBED_DIM-1:0][ACC_W-1:0] acc_bus;

  assign rd_addr = cur_r.rows[fld_r];
  assign mem_we  = (state_r == BK_IDLE) && !q_empty && (q_job.op == OP_WRITE);

  // One lane per table column: all columns of a row are read in the same cycle
  for (genvar l = 0; l < EMBED_DIM; l++) begin : g_lane
    logic [VAL_W-1:0]        mem [TABLE_ROWS];
    logic [VAL_W-1:0]        rd_r;
    logic signed [ACC_W-1:0] acc_r;

    always_ff @(posedge clk) begin
      if (mem_we && (q_job.wr_lane == LANE_W'(l))) mem[q_job.wr_row] <= q_job.wr_value;
      rd_r <= mem[rd_addr];
    end

    always_ff @(posedge clk) begin
      if (acc_clr) begin
        acc_r <= '0;
      end else if (rd_vld_r) begin
        acc_r <= acc_r + ACC_W'($signed(rd_r));
      end
    end

    assign acc_bus[l] = acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      fld_r       <= '0;
      lane_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fld_r       <= fld_nxt;
      lane_r      <= lane_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    fld_nxt    = fld_r;
    lane_nxt   = lane_r;
    rd_vld_nxt = 1'b0;
    q_pop      = 1'b0;
    load_cur   = 1'b0;
    acc_clr    = 1'b0;
    emit       = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_job.op == OP_QUERY) begin
            load_cur  = 1'b1;
            acc_clr   = 1'b1;
            fld_nxt   = '0;
            lane_nxt  = '0;
            state_nxt = q_job.bad ? BK_EMIT : BK_GATHER;
          end
        end
      end
      BK_GATHER: begin
        rd_vld_nxt = 1'b1;
        if (fld_r == cur_r.last_fld) begin
          state_nxt = BK_FINAL;
        end else begin
          fld_nxt = fld_r + FLD_W'(1);
        end
      end
      BK_FINAL: begin
        // last field's read data lands in the accumulators this cycle
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (!out_valid_r || out_tready) begin
          emit = 1'b1;
          if (lane_r == LANE_W'(EMBED_DIM - 1)) begin
            state_nxt = BK_IDLE;
          end else begin
            lane_nxt = lane_r + LANE_W'(1);
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_cur) cur_r <= q_job;
  end

  always_comb begin
    acc_sel = $signed(acc_bus[lane_r]);
    if (cur_r.bad) begin
      sum_sat = '0;
    end else if (acc_sel > SUM_MAX) begin
      sum_sat = SUM_MAX[SUM_W-1:0];
    end else if (acc_sel < SUM_MIN) begin
      sum_sat = SUM_MIN[SUM_W-1:0];
    end else begin
      sum_sat = acc_sel[SUM_W-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_col_r  <= COL_OUT_W'(lane_r);
      out_sum_r  <= sum_sat;
      out_bad_r  <= cur_r.bad;
      out_last_r <= (lane_r == LANE_W'(EMBED_DIM - 1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - SUM_W - COL_OUT_W)'(0), out_sum_r, out_col_r};
  assign out_tuser  = out_bad_r;
  assign out_tlast  = out_last_r;

endmodule

/* rtl/onehot_gather_sum.sv */
// Top level of the one-hot gather-sum (multi-field embedding-bag) block.
// A write request is popped from the queue and written to its column lane, and gives no
// result. A query request leaves the queue, then reads one table row per active field (one
// to four), all eight columns at once from eight column lanes with registered read data, and
// waits in a final state for the last read to reach the accumulators; it then emits its 8
// column sums one by one through the output register, holding while the output stalls, or
// emits 8 zero sums when an index is bad and no row is read. The back end pops the next
// request only after a query has emitted its last sum. The front end classifies requests
// and keeps accepting while the 4-deep queue to the back end has room. Table entries
// hold no reset value and must be written before a query reads them.
module onehot_gather_sum
  import ohgs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // table_row[7:0], table_col[10:8], table_value[26:11], cat_0[34:27], cat_1[42:35],
  // cat_2[50:43], cat_3[58:51], zero fill[63:59]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // opcode[0]
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // column[2:0], sum[20:3], zero fill[23:21]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // bad_index[0]
  output logic                   out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [RANGE_W-1:0]     cfg_data
);

  logic q_full, q_empty, q_push, q_pop;
  job_t q_in, q_out;

  ohgs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_in)
  );

  ohgs_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  ohgs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_job      (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
